// ----- rtl/can_signal_pack_unpack_unit_assert.svh -----
// ----------------------------------------------------------------------------
// CAN signal pack/unpack assertion macros
// Shared property macros for the CAN signal pack/unpack pipeline checks.
// ----------------------------------------------------------------------------
`ifndef CAN_SIGNAL_PACK_UNPACK_UNIT_ASSERT_SVH
`define CAN_SIGNAL_PACK_UNPACK_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csp assertion failed");

`endif

// ----- rtl/csp_pkg.sv -----
// ----------------------------------------------------------------------------
// CAN signal pack/unpack package
// Request and pipeline stage types, widths and the byte swap helper.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int FRAME_W     = 64;
  localparam int VALUE_W     = 32;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 96;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_in;
    logic [2:0]         first_byte;
    logic [2:0]         first_bit;
    logic [5:0]         signal_bits;
    logic               byte_order;
    logic [VALUE_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [5:0]         pos;
    logic [VALUE_W-1:0] ins_mask;
    logic [VALUE_W-1:0] ext_mask;
    logic [VALUE_W-1:0] value;
    logic               moto;
    logic               oor;
  } s1_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [VALUE_W-1:0] value;
    logic               moto;
    logic               oor;
  } s2_t;

  // Reverses the order of the eight frame bytes; bits within a byte keep their place.
  function automatic logic [FRAME_W-1:0] byte_swap(input logic [FRAME_W-1:0] d);
    logic [FRAME_W-1:0] r;
    r = '0;
    for (int i = 0; i < FRAME_W / 8; i++) begin
      r[8*i +: 8] = d[FRAME_W - 8*(i+1) +: 8];
    end
    return r;
  endfunction

endpackage

// ----- rtl/can_signal_pack_unpack_unit.sv -----
// ----------------------------------------------------------------------------
// CAN signal pack/unpack unit
// Three-stage pipeline that inserts a signal into or extracts it from a frame.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ stream: tuser carries the mode (1 inserts,
// 0 extracts) and tdata the frame with its signal descriptor and value.
// Each request yields exactly one result on the out_ stream: the frame after
// insertion and the extracted value in tdata, the range flag in tuser.
// A request passes the decode, shift and output format registers in that
// order before its result is shown on the out_ stream. The block takes one
// request per cycle unless the receiver stalls. Intel and Motorola signals
// share the same shifter, with Motorola handled on the byte-swapped frame.
// A synchronous active-low reset empties all stages; no state is kept.
// When the receiver stalls, each stage holds its request, bubbles are
// filled, and in_tready drops only once every stage is occupied.
// ----------------------------------------------------------------------------
`include "can_signal_pack_unpack_unit_assert.svh"

module can_signal_pack_unpack_unit import csp_pkg::*; #(
  parameter int FRAME_BYTES     = 8,
  parameter int MAX_SIGNAL_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // frame_in[63:0], first_byte[66:64], first_bit[69:67], signal_bits[75:70],
  // byte_order[76], value_in[108:77], zero pad[111:109]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // mode[0]
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // frame_out[63:0], value_out[95:64]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_of_range[0]
  output logic                   out_tuser
);

  req_t               req;
  s1_t                s1_nxt;
  s1_t                s1_r;
  s2_t                s2_nxt;
  s2_t                s2_r;
  logic               v1_r;
  logic               v2_r;
  logic               out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [OUT_TDATA_W-1:0] out_tdata_nxt;
  logic               out_tuser_r;
  logic               ready1;
  logic               ready2;
  logic               ready3;

  assign req.frame_in    = in_tdata[63:0];
  assign req.first_byte  = in_tdata[66:64];
  assign req.first_bit   = in_tdata[69:67];
  assign req.signal_bits = in_tdata[75:70];
  assign req.byte_order  = in_tdata[76];
  assign req.value_in    = in_tdata[108:77];

  csp_decode #(
    .FRAME_BYTES     (FRAME_BYTES),
    .MAX_SIGNAL_BITS (MAX_SIGNAL_BITS)
  ) u_decode (
    .req  (req),
    .mode (in_tuser),
    .s1   (s1_nxt)
  );

  csp_shift u_shift (
    .s1 (s1_r),
    .s2 (s2_nxt)
  );

  assign ready3    = !out_valid_r || out_tready;
  assign ready2    = !v2_r || ready3;
  assign ready1    = !v1_r || ready2;
  assign in_tready = ready1;

  assign out_tdata_nxt = {s2_r.value, s2_r.moto ? byte_swap(s2_r.frame) : s2_r.frame};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ready1) begin
        v1_r <= in_tvalid;
      end
      if (ready2) begin
        v2_r <= v1_r;
      end
      if (ready3) begin
        out_valid_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      s1_r <= s1_nxt;
    end
    if (ready2) begin
      s2_r <= s2_nxt;
    end
    if (ready3) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= s2_r.oor;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `CSP_ASSERT_SAME(a_oor_value_zero, out_tvalid && out_tuser, out_tdata[95:64] == '0)
  `CSP_ASSERT_SAME(a_masks_exclusive, v1_r, (s1_r.ins_mask & s1_r.ext_mask) == '0)
  `CSP_ASSERT_NEXT(a_stage2_holds, v2_r && !ready2, v2_r && $stable(s2_r))
  `CSP_ASSERT_SAME(a_full_stall, v1_r && v2_r && out_tvalid && !out_tready, !in_tready)

endmodule

// ----- rtl/csp_decode.sv -----
// ----------------------------------------------------------------------------
// CAN signal pack/unpack descriptor decode
// Saturates the length, finds the bit position, range check and field masks.
// ----------------------------------------------------------------------------
module csp_decode import csp_pkg::*; #(
  parameter int FRAME_BYTES     = 8,
  parameter int MAX_SIGNAL_BITS = 32
) (
  input  req_t req,
  input  logic mode,
  output s1_t  s1
);

  localparam logic [6:0] FRAME_BITS   = 7'(8 * FRAME_BYTES);
  localparam logic [3:0] FRAME_BYTE_N = 4'(FRAME_BYTES);
  localparam logic [5:0] MAX_LEN      = 6'(MAX_SIGNAL_BITS);
  localparam logic [6:0] FRAME_TOP    = 7'(FRAME_W);

  logic [5:0]         len;
  logic [5:0]         start;
  logic [6:0]         span_end;
  logic [6:0]         moto_base;
  logic               oor;
  logic [VALUE_W-1:0] len_mask;
  logic [VALUE_W-1:0] ins_mask;

  // Motorola signals are handled on the byte-swapped frame, where they become
  // contiguous little-endian fields that start at moto_base.
  always_comb begin
    len       = (req.signal_bits > MAX_LEN) ? MAX_LEN : req.signal_bits;
    start     = req.byte_order ? {req.first_byte, ~req.first_bit}
                               : {req.first_byte, req.first_bit};
    span_end  = {1'b0, start} + {1'b0, len};
    if (len == '0) begin
      oor = {1'b0, req.first_byte} >= FRAME_BYTE_N;
    end else begin
      oor = span_end > FRAME_BITS;
    end
    moto_base = FRAME_TOP - span_end;
    len_mask  = VALUE_W'((33'd1 << len) - 33'd1);
    ins_mask  = (!oor && mode) ? len_mask : '0;

    s1.frame    = req.byte_order ? byte_swap(req.frame_in) : req.frame_in;
    s1.pos      = req.byte_order ? moto_base[5:0] : start;
    s1.ins_mask = ins_mask;
    s1.ext_mask = (!oor && !mode) ? len_mask : '0;
    s1.value    = req.value_in & ins_mask;
    s1.moto     = req.byte_order;
    s1.oor      = oor;
  end

endmodule

// ----- rtl/csp_shift.sv -----
// ----------------------------------------------------------------------------
// CAN signal pack/unpack field shifter
// Inserts the masked value at its position or extracts the field from there.
// ----------------------------------------------------------------------------
module csp_shift import csp_pkg::*; (
  input  s1_t s1,
  output s2_t s2
);

  logic [FRAME_W-1:0] field_mask;
  logic [FRAME_W-1:0] field_val;
  logic [FRAME_W-1:0] shifted;

  always_comb begin
    field_mask = {{(FRAME_W-VALUE_W){1'b0}}, s1.ins_mask} << s1.pos;
    field_val  = {{(FRAME_W-VALUE_W){1'b0}}, s1.value} << s1.pos;
    shifted    = s1.frame >> s1.pos;

    s2.frame = (s1.frame & ~field_mask) | field_val;
    s2.value = shifted[VALUE_W-1:0] & s1.ext_mask;
    s2.moto  = s1.moto;
    s2.oor   = s1.oor;
  end

endmodule

// ----- tb/csp_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// CAN signal pack/unpack testbench package
// Request and result layouts, mode and byte order codes shared by the
// stimulus and the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csp_tb_pkg;

  localparam int SIGNAL_FRAME_BYTES = 8;
  localparam int SIGNAL_MAX_BITS    = 32;

  typedef enum bit {
    MODE_EXTRACT = 1'b0,
    MODE_INSERT  = 1'b1
  } csp_mode_e;

  typedef enum bit {
    ORDER_INTEL    = 1'b0,
    ORDER_MOTOROLA = 1'b1
  } csp_order_e;

  // Request payload of in_tdata; the last member sits in the lowest bits.
  typedef struct packed {
    logic [2:0]  pad;
    logic [31:0] value_in;
    logic        byte_order;
    logic [5:0]  signal_bits;
    logic [2:0]  first_bit;
    logic [2:0]  first_byte;
    logic [63:0] frame_in;
  } signal_request_t;

  // Result payload of out_tdata.
  typedef struct packed {
    logic [31:0] value_out;
    logic [63:0] frame_out;
  } signal_payload_t;

endpackage

// ----- tb/can_signal_pack_unpack_unit_checker.sv -----
// ----------------------------------------------------------------------------
// CAN signal pack/unpack checker
// Watches both streams, predicts the frame, value and range flag of every
// accepted request and compares each accepted result with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module can_signal_pack_unpack_unit_checker
  import csp_pkg::*;
  import csp_tb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // frame_in, first_byte, first_bit, signal_bits, byte_order, value_in, pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // mode
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // frame_out, value_out
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  // out_of_range
  input  logic                   out_tuser,
  output int                     error_count,
  output int                     pending_count,
  output int                     checked_count
);

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [VALUE_W-1:0] value;
    logic               oor;
  } signal_result_t;

  signal_result_t expected_signals[$];

  function automatic signal_result_t predict_signal(input csp_mode_e mode,
                                                    input signal_request_t req);
    int             len;
    int             walk_start;
    int             last_byte;
    int             q;
    int             fb;
    int             vb;
    logic           motorola;
    signal_result_t res;
    motorola = (req.byte_order == ORDER_MOTOROLA);
    len = int'(req.signal_bits);
    if (len > SIGNAL_MAX_BITS) len = SIGNAL_MAX_BITS;
    res.frame = req.frame_in;
    res.value = '0;
    res.oor = 1'b0;
    // Motorola signals walk the frame in a numbering that runs from bit 7
    // down to bit 0 in each byte.
    walk_start = int'(req.first_byte) * 8 +
                 (motorola ? 7 - int'(req.first_bit) : int'(req.first_bit));
    last_byte = (len == 0) ? int'(req.first_byte) : (walk_start + len - 1) / 8;
    if (last_byte >= SIGNAL_FRAME_BYTES) begin
      res.oor = 1'b1;
    end else begin
      for (int k = 0; k < len; k++) begin
        q = walk_start + k;
        fb = motorola ? (q / 8) * 8 + 7 - (q % 8) : q;
        vb = motorola ? len - 1 - k : k;
        if (mode == MODE_INSERT) begin
          res.frame[fb] = req.value_in[vb];
        end else begin
          res.value[vb] = req.frame_in[fb];
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    signal_result_t  got;
    signal_result_t  want;
    signal_payload_t payload;
    int              new_errors;
    int              new_checks;
    new_errors = 0;
    new_checks = 0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        payload = out_tdata;
        got.frame = payload.frame_out;
        got.value = payload.value_out;
        got.oor = out_tuser;
        new_checks = 1;
        if (expected_signals.size() == 0) begin
          $display("%0t: result with no request waiting: frame %h value %h range %b",
                   $time, got.frame, got.value, got.oor);
          new_errors++;
        end else begin
          want = expected_signals.pop_front();
          if (got.frame !== want.frame) begin
            $display("%0t: frame_out expected %h actual %h", $time, want.frame, got.frame);
            new_errors++;
          end
          if (got.value !== want.value) begin
            $display("%0t: value_out expected %h actual %h", $time, want.value, got.value);
            new_errors++;
          end
          if (got.oor !== want.oor) begin
            $display("%0t: out_of_range expected %b actual %b", $time, want.oor, got.oor);
            new_errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_signals.push_back(predict_signal(csp_mode_e'(in_tuser), in_tdata));
      end
    end
    error_count <= error_count + new_errors;
    checked_count <= checked_count + new_checks;
    pending_count <= expected_signals.size();
  end

endmodule

// ----- tb/can_signal_pack_unpack_unit_tb.sv -----
// ----------------------------------------------------------------------------
// CAN signal pack/unpack unit testbench
// Drives directed and random insert and extract requests in both byte
// orders, with random stalls on both streams, and reports the verdict of the
// checker that runs beside the unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module can_signal_pack_unpack_unit_tb;
  import csp_pkg::*;
  import csp_tb_pkg::*;

  localparam int RANDOM_REQUESTS = 1630;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  int error_count;
  int pending_count;
  int checked_count;
  int sent_count     = 0;
  int insert_count   = 0;
  int motorola_count = 0;
  bit steady_phase   = 1'b0;

  can_signal_pack_unpack_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  can_signal_pack_unpack_unit_checker checker_inst (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .error_count  (error_count),
    .pending_count(pending_count),
    .checked_count(checked_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= steady_phase || ($urandom_range(99) >= 15);
  end

  task automatic send_request(input csp_mode_e mode, input logic [63:0] frame,
                              input int fbyte, input int fbit, input int nbits,
                              input csp_order_e order, input logic [31:0] value);
    signal_request_t req;
    while (!steady_phase && $urandom_range(99) < 15) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    req = '0;
    req.frame_in = frame;
    req.first_byte = fbyte[2:0];
    req.first_bit = fbit[2:0];
    req.signal_bits = nbits[5:0];
    req.byte_order = order;
    req.value_in = value;
    in_tdata = req;
    in_tuser = mode;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent_count++;
    if (mode == MODE_INSERT) insert_count++;
    if (order == ORDER_MOTOROLA) motorola_count++;
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  initial begin
    csp_mode_e   mode;
    csp_order_e  order;
    logic [63:0] frame;
    int          fbyte;
    int          fbit;
    int          nbits;
    int          room;
    int          pick;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Frame corners, full-width signals, the last byte and one bit past it.
    send_request(MODE_EXTRACT, 64'h0000_0000_0000_0001, 0, 0, 1, ORDER_INTEL, '1);
    send_request(MODE_INSERT, '0, 0, 0, 32, ORDER_INTEL, 32'hFFFF_FFFF);
    send_request(MODE_INSERT, '1, 4, 0, 32, ORDER_INTEL, 32'h0000_0000);
    send_request(MODE_INSERT, '1, 4, 1, 32, ORDER_INTEL, 32'h1234_5678);
    send_request(MODE_EXTRACT, '1, 4, 1, 32, ORDER_INTEL, '0);
    send_request(MODE_EXTRACT, 64'h8000_0000_0000_0000, 7, 7, 1, ORDER_INTEL, '0);
    send_request(MODE_INSERT, '0, 7, 7, 2, ORDER_INTEL, 32'h3);
    send_request(MODE_INSERT, '0, 0, 7, 32, ORDER_MOTOROLA, 32'h8000_0001);
    send_request(MODE_EXTRACT, 64'h0123_4567_89AB_CDEF, 0, 7, 32, ORDER_MOTOROLA, '0);
    send_request(MODE_INSERT, '1, 4, 7, 32, ORDER_MOTOROLA, 32'h0000_0000);
    send_request(MODE_EXTRACT, '1, 4, 6, 32, ORDER_MOTOROLA, '0);
    send_request(MODE_INSERT, '0, 7, 0, 1, ORDER_MOTOROLA, 32'h1);
    send_request(MODE_INSERT, '0, 7, 0, 2, ORDER_MOTOROLA, 32'h3);
    send_request(MODE_INSERT, '0, 1, 3, 12, ORDER_MOTOROLA, 32'h0000_0ABC);
    send_request(MODE_EXTRACT, 64'hFEDC_BA98_7654_3210, 1, 3, 12, ORDER_MOTOROLA, '0);
    // Empty signals, lengths above the maximum and a plain in-range insert.
    send_request(MODE_INSERT, 64'hDEAD_BEEF_CAFE_F00D, 3, 5, 0, ORDER_INTEL, '1);
    send_request(MODE_EXTRACT, '1, 7, 7, 0, ORDER_MOTOROLA, '0);
    send_request(MODE_INSERT, '0, 0, 0, 33, ORDER_INTEL, 32'hFFFF_FFFF);
    send_request(MODE_EXTRACT, 64'h0F0F_F0F0_A5A5_5A5A, 2, 4, 63, ORDER_INTEL, '0);
    send_request(MODE_INSERT, '1, 1, 7, 63, ORDER_MOTOROLA, 32'h0);
    send_request(MODE_EXTRACT, 64'h0F0F_F0F0_A5A5_5A5A, 0, 7, 40, ORDER_MOTOROLA, '0);
    send_request(MODE_INSERT, '0, 2, 5, 17, ORDER_INTEL, 32'hFFFE_AAAA);
    wait_drained();

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      steady_phase = (i >= 500 && i < 800);
      if (i == 1100) wait_drained();
      mode = csp_mode_e'($urandom_range(1));
      order = csp_order_e'($urandom_range(1));
      fbyte = $urandom_range(7);
      fbit = $urandom_range(7);
      room = 64 - fbyte * 8 - ((order == ORDER_INTEL) ? fbit : 7 - fbit);
      if (room > SIGNAL_MAX_BITS) room = SIGNAL_MAX_BITS;
      pick = $urandom_range(99);
      if (pick < 70) nbits = $urandom_range(room, 1);
      else if (pick < 75) nbits = 0;
      else if (pick < 82) nbits = $urandom_range(63, 33);
      else nbits = $urandom_range(32, 1);
      pick = $urandom_range(99);
      if (pick < 8) frame = '0;
      else if (pick < 16) frame = '1;
      else frame = {$urandom, $urandom};
      send_request(mode, frame, fbyte, fbit, nbits, order, $urandom);
    end
    steady_phase = 1'b0;

    wait_drained();
    repeat (8) @(negedge clk);
    $display("Sent %0d requests: %0d inserts, %0d extracts, %0d in Motorola order.",
             sent_count, insert_count, sent_count - insert_count, motorola_count);
    $display("Checked %0d results, including empty, oversized and out-of-frame signals.",
             checked_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("can_signal_pack_unpack_unit_tb: clean");
    end else begin
      $display("can_signal_pack_unpack_unit_tb: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("can_signal_pack_unpack_unit_tb: errors");
    $finish;
  end

endmodule
